// ----- src/bracket_match_checker_macros.svh -----
// ----------------------------------------------------------------------------
// bracket_match_checker assertion macros
// Shared property wrappers for the checker's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef BRACKET_MATCH_CHECKER_MACROS_SVH
`define BRACKET_MATCH_CHECKER_MACROS_SVH

// same-cycle implication
`define BMC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmc assertion failed");

// next-cycle implication
`define BMC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmc assertion failed");

`endif

// ----- src/bmc_pkg.sv -----
// ----------------------------------------------------------------------------
// bmc_pkg
// Types, constants and lookup functions shared by the bracket checker.
// ----------------------------------------------------------------------------
package bmc_pkg;

   localparam int STACK_DEPTH = 63;
   localparam int POS_BITS    = 8;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int BYTE_W      = 8;

   localparam logic [BYTE_W-1:0] ERR_MAX = 8'hFF;

   // result kinds
   localparam logic [2:0] KIND_UNMATCHED_CLOSE = 3'd0;
   localparam logic [2:0] KIND_MISMATCH        = 3'd1;
   localparam logic [2:0] KIND_UNMATCHED_OPEN  = 3'd2;
   localparam logic [2:0] KIND_OVERFLOW        = 3'd3;
   localparam logic [2:0] KIND_SUMMARY         = 3'd4;

   // request types
   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_END  = 1'b1;

   // bracket codes held on the stack
   localparam logic [1:0] BR_ROUND  = 2'd0;
   localparam logic [1:0] BR_SQUARE = 2'd1;
   localparam logic [1:0] BR_CURLY  = 2'd2;

   localparam logic [BYTE_W-1:0] CH_OPEN_ROUND   = 8'h28;
   localparam logic [BYTE_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_OPEN_CURLY   = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_CLOSE_ROUND  = 8'h29;
   localparam logic [BYTE_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_CLOSE_CURLY  = 8'h7D;

   typedef struct packed {
      logic [1:0]          code;
      logic [POS_BITS-1:0] pos;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_op_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] code;
   } bracket_type;

   function automatic bracket_type open_lookup(logic [BYTE_W-1:0] c);
      bracket_type r;
      r.hit  = 1'b1;
      r.code = BR_ROUND;
      unique case (c)
         CH_OPEN_ROUND:  r.code = BR_ROUND;
         CH_OPEN_SQUARE: r.code = BR_SQUARE;
         CH_OPEN_CURLY:  r.code = BR_CURLY;
         default:        r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   function automatic bracket_type close_lookup(logic [BYTE_W-1:0] c);
      bracket_type r;
      r.hit  = 1'b1;
      r.code = BR_ROUND;
      unique case (c)
         CH_CLOSE_ROUND:  r.code = BR_ROUND;
         CH_CLOSE_SQUARE: r.code = BR_SQUARE;
         CH_CLOSE_CURLY:  r.code = BR_CURLY;
         default:         r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] open_char_of(logic [1:0] code);
      logic [BYTE_W-1:0] c;
      unique case (code)
         BR_ROUND:  c = CH_OPEN_ROUND;
         BR_SQUARE: c = CH_OPEN_SQUARE;
         default:   c = CH_OPEN_CURLY;
      endcase
      return c;
   endfunction

   // low byte of a position, zero-extended when positions are narrower
   function automatic logic [BYTE_W-1:0] pos_byte(logic [POS_BITS-1:0] p);
      logic [POS_BITS+BYTE_W-1:0] wide;
      wide = {{BYTE_W{1'b0}}, p};
      return wide[BYTE_W-1:0];
   endfunction

endpackage

// ----- src/bmc_cell.sv -----
// ----------------------------------------------------------------------------
// bmc_cell
// One stack slot: takes the entry above on push, the entry below on pop.
// ----------------------------------------------------------------------------
module bmc_cell (
   input  logic                    clock,
   input  bmc_pkg::stack_op_type   op,
   input  bmc_pkg::entry_type      above,
   input  bmc_pkg::entry_type      below,
   output bmc_pkg::entry_type      data
);

   bmc_pkg::entry_type data_ff;
   bmc_pkg::entry_type data_in;

   always_comb begin
      priority if (op.push) begin
         data_in = above;
      end else if (op.pop) begin
         data_in = below;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- src/bmc_stack.sv -----
// ----------------------------------------------------------------------------
// bmc_stack
// Shift stack built from a row of cells; cell 0 is the top of stack.
// ----------------------------------------------------------------------------
module bmc_stack (
   input  logic                    clock,
   input  bmc_pkg::stack_op_type   op,
   input  bmc_pkg::entry_type      push_entry,
   output bmc_pkg::entry_type      top
);

   bmc_pkg::entry_type cell_q [bmc_pkg::STACK_DEPTH];

   for (genvar i = 0; i < bmc_pkg::STACK_DEPTH; i++) begin : g_cell
      bmc_pkg::entry_type above;
      bmc_pkg::entry_type below;

      if (i == 0) begin : g_head
         assign above = push_entry;
      end else begin : g_body
         assign above = cell_q[i-1];
      end

      // the bottom cell refills with zeros on pop
      if (i == bmc_pkg::STACK_DEPTH - 1) begin : g_tail
         assign below = '0;
      end else begin : g_link
         assign below = cell_q[i+1];
      end

      bmc_cell u_cell (
         .clock (clock),
         .op    (op),
         .above (above),
         .below (below),
         .data  (cell_q[i])
      );
   end

   assign top = cell_q[0];

endmodule

// ----- src/bracket_match_checker.sv -----
// ----------------------------------------------------------------------------
// bracket_match_checker: bracket stack checker with error reports
// A character's result is registered at its accept edge.
// Throughput: one character per cycle; a waiting result or an end-item drain holds off the input.
// End item with N stacked opens: N+1 results, the first at the edge after the
// accept, one per cycle while the output takes them; input waits for the summary.
// Reset: synchronous; clears control state, counters and result valid only.
// ----------------------------------------------------------------------------
`include "bracket_match_checker_macros.svh"

module bracket_match_checker (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_ch,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_error_number,
   output logic [7:0]  rsp_close_char,
   output logic [7:0]  rsp_close_pos,
   output logic [7:0]  rsp_open_char,
   output logic [7:0]  rsp_open_pos,
   output logic        rsp_valid_res,
   output logic [7:0]  rsp_error_total,
   output logic        rsp_last
);

   localparam logic ST_RUN   = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   localparam int CW = bmc_pkg::CNT_W;
   localparam int PW = bmc_pkg::POS_BITS;

   logic                state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [PW-1:0]       pos_ff,   pos_in;
   logic [7:0]          err_ff,   err_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          kind_ff,  kind_in;
   logic [7:0]          num_ff,   num_in;
   logic [7:0]          cchar_ff, cchar_in;
   logic [7:0]          cpos_ff,  cpos_in;
   logic [7:0]          ochar_ff, ochar_in;
   logic [7:0]          opos_ff,  opos_in;
   logic                vres_ff,  vres_in;
   logic [7:0]          total_ff, total_in;
   logic                last_ff,  last_in;

   logic                slot_free;
   logic                in_acc;
   logic                load;
   logic [7:0]          err_next;
   logic [7:0]          pos8;
   logic                summary_load;
   logic                all_clear;
   logic                open_shown;
   bmc_pkg::bracket_type  open_br, close_br;
   bmc_pkg::stack_op_type op;
   bmc_pkg::entry_type    push_entry, top;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_RUN) && slot_free;
   assign in_acc    = req_valid && req_ready;
   assign err_next  = (err_ff == bmc_pkg::ERR_MAX) ? err_ff : err_ff + 8'd1;
   assign pos8      = bmc_pkg::pos_byte(pos_ff);
   assign open_br   = bmc_pkg::open_lookup(req_ch);
   assign close_br  = bmc_pkg::close_lookup(req_ch);
   assign push_entry.code = open_br.code;
   assign push_entry.pos  = pos_ff;

   bmc_stack u_stack (
      .clock      (clock),
      .op         (op),
      .push_entry (push_entry),
      .top        (top)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      err_in   = err_ff;
      op       = '0;
      load     = 1'b0;
      kind_in  = bmc_pkg::KIND_SUMMARY;
      num_in   = '0;
      cchar_in = '0;
      cpos_in  = '0;
      ochar_in = '0;
      opos_in  = '0;
      vres_in  = 1'b0;
      total_in = '0;
      last_in  = 1'b1;

      unique case (state_ff)
         ST_RUN: begin
            if (in_acc) begin
               unique case (req_type)
                  bmc_pkg::REQ_END: begin
                     state_in = ST_DRAIN;
                  end
                  default: begin
                     if (pos_ff != {PW{1'b1}}) begin
                        pos_in = pos_ff + PW'(1);
                     end
                     if (open_br.hit) begin
                        if (count_ff < CW'(bmc_pkg::STACK_DEPTH)) begin
                           op.push  = 1'b1;
                           count_in = count_ff + CW'(1);
                        end else begin
                           load     = 1'b1;
                           err_in   = err_next;
                           kind_in  = bmc_pkg::KIND_OVERFLOW;
                           num_in   = err_next;
                           cpos_in  = pos8;
                           ochar_in = req_ch;
                           opos_in  = pos8;
                        end
                     end else if (close_br.hit) begin
                        if (count_ff == '0) begin
                           load     = 1'b1;
                           err_in   = err_next;
                           kind_in  = bmc_pkg::KIND_UNMATCHED_CLOSE;
                           num_in   = err_next;
                           cchar_in = req_ch;
                           cpos_in  = pos8;
                        end else begin
                           op.pop   = 1'b1;
                           count_in = count_ff - CW'(1);
                           if (top.code != close_br.code) begin
                              load     = 1'b1;
                              err_in   = err_next;
                              kind_in  = bmc_pkg::KIND_MISMATCH;
                              num_in   = err_next;
                              cchar_in = req_ch;
                              cpos_in  = pos8;
                              ochar_in = bmc_pkg::open_char_of(top.code);
                              opos_in  = bmc_pkg::pos_byte(top.pos);
                           end
                        end
                     end
                  end
               endcase
            end
         end
         default: begin
            // drain: one unmatched open per free output slot, then the summary
            if (slot_free) begin
               load = 1'b1;
               if (count_ff != '0) begin
                  op.pop   = 1'b1;
                  count_in = count_ff - CW'(1);
                  err_in   = err_next;
                  kind_in  = bmc_pkg::KIND_UNMATCHED_OPEN;
                  num_in   = err_next;
                  ochar_in = bmc_pkg::open_char_of(top.code);
                  opos_in  = bmc_pkg::pos_byte(top.pos);
                  last_in  = 1'b0;
               end else begin
                  kind_in  = bmc_pkg::KIND_SUMMARY;
                  vres_in  = (err_ff == '0);
                  total_in = err_ff;
                  state_in = ST_RUN;
                  count_in = '0;
                  pos_in   = '0;
                  err_in   = '0;
               end
            end
         end
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         count_ff     <= '0;
         pos_ff       <= '0;
         err_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload holds until the transaction completes
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         num_ff   <= num_in;
         cchar_ff <= cchar_in;
         cpos_ff  <= cpos_in;
         ochar_ff <= ochar_in;
         opos_ff  <= opos_in;
         vres_ff  <= vres_in;
         total_ff <= total_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_error_number = num_ff;
   assign rsp_close_char   = cchar_ff;
   assign rsp_close_pos    = cpos_ff;
   assign rsp_open_char    = ochar_ff;
   assign rsp_open_pos     = opos_ff;
   assign rsp_valid_res    = vres_ff;
   assign rsp_error_total  = total_ff;
   assign rsp_last         = last_ff;

   assign summary_load = load && (kind_in == bmc_pkg::KIND_SUMMARY);
   assign all_clear    = (state_ff == ST_RUN) && (count_ff == '0) && (pos_ff == '0)
                         && (err_ff == '0);
   assign open_shown   = rsp_valid_ff && (kind_ff == bmc_pkg::KIND_UNMATCHED_OPEN);

   `BMC_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(bmc_pkg::STACK_DEPTH))
   `BMC_ASSERT_IMP(a_no_accept_in_drain, clock, reset, state_ff == ST_DRAIN, !req_ready)
   `BMC_ASSERT_NXT(a_summary_clears, clock, reset, summary_load, all_clear)
   `BMC_ASSERT_IMP(a_open_not_last, clock, reset, open_shown, !last_ff)
   `BMC_ASSERT_IMP(a_push_pop_excl, clock, reset, 1'b1, !(op.push && op.pop))

endmodule

// ----- test/bracket_match_checker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_match_checker_tb
// Self-checking bench for the bracket checker. A directed table covers the
// corner cases, then random expressions (tidy, noisy, overflowing and a long run of
// stray closes) go in, all but the stray closes under random idling on both sides.
// Each report is compared with its typed row or an in-bench bracket stack predictor.
// ----------------------------------------------------------------------------
module bracket_match_checker_tb;

   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 150;
   localparam logic [bmc_pkg::POS_BITS-1:0] POS_TOP = '1;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] number;
      logic [7:0] close_char;
      logic [7:0] close_pos;
      logic [7:0] open_char;
      logic [7:0] open_pos;
      logic       valid_res;
      logic [7:0] total;
      logic       last;
   } bracket_report_type;

   typedef struct packed {
      logic               is_end;
      logic [7:0]         ch;
      logic               typed;
      bracket_report_type rep;
   } dir_row_type;

   localparam bracket_report_type NO_REPORT = '0;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_type = bmc_pkg::REQ_CHAR;
   logic [7:0] req_ch = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_error_number;
   logic [7:0] rsp_close_char;
   logic [7:0] rsp_close_pos;
   logic [7:0] rsp_open_char;
   logic [7:0] rsp_open_pos;
   logic       rsp_valid_res;
   logic [7:0] rsp_error_total;
   logic       rsp_last;

   // side-band copy of the current row, held with the payload
   logic               row_typed = 1'b0;
   bracket_report_type row_report = '0;

   logic steady_mode = 1'b0;
   int   hold_requests = 0;
   int   hold_served = 0;
   int   hold_left = 0;
   int   cycle_count = 0;
   int   fail_count = 0;
   int   items_in = 0;
   int   reports_checked = 0;
   int   kinds_seen [5] = '{default: 0};

   // predictor state
   bmc_pkg::entry_type           open_stack [bmc_pkg::STACK_DEPTH];
   logic [bmc_pkg::CNT_W-1:0]    depth_now = '0;
   logic [bmc_pkg::POS_BITS-1:0] char_pos = '0;
   logic [7:0]                   err_count = '0;
   bracket_report_type           fresh_reports [$];
   bracket_report_type           awaited_reports [$];

   dir_row_type directed_rows [0:20];

   bracket_match_checker u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_ch           (req_ch),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_error_number (rsp_error_number),
      .rsp_close_char   (rsp_close_char),
      .rsp_close_pos    (rsp_close_pos),
      .rsp_open_char    (rsp_open_char),
      .rsp_open_pos     (rsp_open_pos),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_error_total  (rsp_error_total),
      .rsp_last         (rsp_last)
   );

   always #6 clock = ~clock;

   function automatic logic [7:0] open_char_for(logic [1:0] code);
      case (code)
         bmc_pkg::BR_ROUND:  return bmc_pkg::CH_OPEN_ROUND;
         bmc_pkg::BR_SQUARE: return bmc_pkg::CH_OPEN_SQUARE;
         default:            return bmc_pkg::CH_OPEN_CURLY;
      endcase
   endfunction

   function automatic logic [7:0] close_char_for(logic [1:0] code);
      case (code)
         bmc_pkg::BR_ROUND:  return bmc_pkg::CH_CLOSE_ROUND;
         bmc_pkg::BR_SQUARE: return bmc_pkg::CH_CLOSE_SQUARE;
         default:            return bmc_pkg::CH_CLOSE_CURLY;
      endcase
   endfunction

   function automatic logic [7:0] bump_sat(logic [7:0] v);
      return (v == bmc_pkg::ERR_MAX) ? v : v + 8'd1;
   endfunction

   function automatic bracket_report_type close_rep(logic [7:0] num, logic [7:0] c,
                                                    logic [7:0] pos);
      bracket_report_type r;
      r = '0;
      r.kind = bmc_pkg::KIND_UNMATCHED_CLOSE;
      r.number = num;
      r.close_char = c;
      r.close_pos = pos;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic bracket_report_type summary_rep(logic ok, logic [7:0] total);
      bracket_report_type r;
      r = '0;
      r.kind = bmc_pkg::KIND_SUMMARY;
      r.valid_res = ok;
      r.total = total;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic string show(bracket_report_type r);
      return $sformatf("kind %0d num %0d close %h@%0d open %h@%0d ok %b total %0d last %b",
                       r.kind, r.number, r.close_char, r.close_pos, r.open_char,
                       r.open_pos, r.valid_res, r.total, r.last);
   endfunction

   // reports caused by one transaction, into fresh_reports
   task automatic predict_reports(input logic is_end, input logic [7:0] c);
      bracket_report_type r;
      logic               is_open;
      logic               is_close;
      logic [1:0]         code;
      bmc_pkg::entry_type top;
      fresh_reports.delete();
      if (is_end == bmc_pkg::REQ_END) begin
         while (depth_now != 0) begin
            depth_now = depth_now - 1'b1;
            err_count = bump_sat(err_count);
            r = '0;
            r.kind = bmc_pkg::KIND_UNMATCHED_OPEN;
            r.number = err_count;
            r.open_char = open_char_for(open_stack[depth_now].code);
            r.open_pos = 8'(open_stack[depth_now].pos);
            fresh_reports.push_back(r);
         end
         fresh_reports.push_back(summary_rep(err_count == 0, err_count));
         char_pos = '0;
         err_count = '0;
      end else begin
         is_open = 1'b0;
         is_close = 1'b0;
         code = bmc_pkg::BR_ROUND;
         case (c)
            bmc_pkg::CH_OPEN_ROUND:   begin is_open = 1'b1; code = bmc_pkg::BR_ROUND; end
            bmc_pkg::CH_OPEN_SQUARE:  begin is_open = 1'b1; code = bmc_pkg::BR_SQUARE; end
            bmc_pkg::CH_OPEN_CURLY:   begin is_open = 1'b1; code = bmc_pkg::BR_CURLY; end
            bmc_pkg::CH_CLOSE_ROUND:  begin is_close = 1'b1; code = bmc_pkg::BR_ROUND; end
            bmc_pkg::CH_CLOSE_SQUARE: begin is_close = 1'b1; code = bmc_pkg::BR_SQUARE; end
            bmc_pkg::CH_CLOSE_CURLY:  begin is_close = 1'b1; code = bmc_pkg::BR_CURLY; end
            default: ;
         endcase
         if (is_open) begin
            if (depth_now < bmc_pkg::STACK_DEPTH) begin
               open_stack[depth_now].code = code;
               open_stack[depth_now].pos = char_pos;
               depth_now = depth_now + 1'b1;
            end else begin
               // full stack: reported, not pushed
               err_count = bump_sat(err_count);
               r = '0;
               r.kind = bmc_pkg::KIND_OVERFLOW;
               r.number = err_count;
               r.close_pos = 8'(char_pos);
               r.open_char = c;
               r.open_pos = 8'(char_pos);
               r.last = 1'b1;
               fresh_reports.push_back(r);
            end
         end else if (is_close) begin
            if (depth_now == 0) begin
               err_count = bump_sat(err_count);
               fresh_reports.push_back(close_rep(err_count, c, 8'(char_pos)));
            end else begin
               depth_now = depth_now - 1'b1;
               top = open_stack[depth_now];
               if (top.code != code) begin
                  err_count = bump_sat(err_count);
                  r = '0;
                  r.kind = bmc_pkg::KIND_MISMATCH;
                  r.number = err_count;
                  r.close_char = c;
                  r.close_pos = 8'(char_pos);
                  r.open_char = open_char_for(top.code);
                  r.open_pos = 8'(top.pos);
                  r.last = 1'b1;
                  fresh_reports.push_back(r);
               end
            end
         end
         if (char_pos != POS_TOP)
            char_pos = char_pos + 1'b1;
      end
   endtask

   // input side: predict on acceptance; output side: ready and checking
   always @(posedge clock) begin
      bracket_report_type got;
      bracket_report_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            items_in++;
            predict_reports(req_type, req_ch);
            if (row_typed)
               awaited_reports.push_back(row_report);
            else
               foreach (fresh_reports[i]) awaited_reports.push_back(fresh_reports[i]);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_kind, rsp_error_number, rsp_close_char, rsp_close_pos,
                    rsp_open_char, rsp_open_pos, rsp_valid_res, rsp_error_total, rsp_last};
            reports_checked++;
            if (got.kind <= bmc_pkg::KIND_SUMMARY) kinds_seen[got.kind]++;
            if (awaited_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected report: %s", show(got));
            end else begin
               want = awaited_reports.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("report mismatch at cycle %0d", cycle_count);
                     $display("  expected %s", show(want));
                     $display("  actual   %s", show(got));
                  end
               end
            end
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (hold_requests != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_mode || ($urandom_range(99) >= 34);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d reports outstanding",
                  cycle_count, awaited_reports.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic offer(input logic is_end, input logic [7:0] c, input logic tp,
                        input bracket_report_type rep);
      while (!steady_mode && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= is_end;
      req_ch <= c;
      row_typed <= tp;
      row_report <= rep;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_reports.size() != 0) @(posedge clock);
   endtask

   // tidy: balanced brackets with random filler; otherwise bracket-heavy noise
   task automatic send_expression(input int len, input bit tidy);
      logic [1:0] open_codes [$];
      logic [1:0] code;
      logic [7:0] c;
      int         r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(99);
         code = 2'($urandom_range(2));
         if (!tidy)
            c = (r < 60) ? ($urandom_range(1) ? open_char_for(code) : close_char_for(code))
                         : 8'($urandom_range(255));
         else if (open_codes.size() != 0 && (r < 35 || len - i <= open_codes.size()))
            c = close_char_for(open_codes.pop_back());
         else if (r < 70 && len - i - 1 > open_codes.size()) begin
            c = open_char_for(code);
            open_codes.push_back(code);
         end else
            c = 8'($urandom_range(255));
         offer(bmc_pkg::REQ_CHAR, c, 1'b0, NO_REPORT);
      end
      offer(bmc_pkg::REQ_END, 8'($urandom_range(255)), 1'b0, NO_REPORT);
   endtask

   initial begin
      int   opens;
      int   target;
      bit   held;
      directed_rows = '{
         '{bmc_pkg::REQ_CHAR, bmc_pkg::CH_CLOSE_ROUND, 1'b1,
           close_rep(8'd1, bmc_pkg::CH_CLOSE_ROUND, 8'd0)},
         '{bmc_pkg::REQ_END,  8'h00,                    1'b1, summary_rep(1'b0, 8'd1)},
         '{bmc_pkg::REQ_END,  8'h00,                    1'b1, summary_rep(1'b1, 8'd0)},
         '{bmc_pkg::REQ_CHAR, 8'h61,                    1'b0, NO_REPORT},
         '{bmc_pkg::REQ_CHAR, bmc_pkg::CH_OPEN_ROUND,   1'b0, NO_REPORT},
         '{bmc_pkg::REQ_CHAR, bmc_pkg::CH_OPEN_SQUARE,  1'b0, NO_REPORT},
         '{bmc_pkg::REQ_CHAR, bmc_pkg::CH_OPEN_CURLY,   1'b0, NO_REPORT},
         '{bmc_pkg::REQ_CHAR, bmc_pkg::CH_CLOSE_CURLY,  1'b0, NO_REPORT},
         '{bmc_pkg::REQ_CHAR, bmc_pkg::CH_CLOSE_ROUND,  1'b0, NO_REPORT},  // pops '['
         '{bmc_pkg::REQ_CHAR, bmc_pkg::CH_CLOSE_SQUARE, 1'b0, NO_REPORT},  // pops '('
         '{bmc_pkg::REQ_CHAR, bmc_pkg::CH_CLOSE_CURLY,  1'b0, NO_REPORT},
         '{bmc_pkg::REQ_CHAR, 8'h00,                    1'b0, NO_REPORT},
         '{bmc_pkg::REQ_CHAR, 8'hFF,                    1'b0, NO_REPORT},
         '{bmc_pkg::REQ_CHAR, bmc_pkg::CH_OPEN_ROUND,   1'b0, NO_REPORT},
         '{bmc_pkg::REQ_CHAR, bmc_pkg::CH_OPEN_CURLY,   1'b0, NO_REPORT},
         '{bmc_pkg::REQ_CHAR, bmc_pkg::CH_OPEN_SQUARE,  1'b0, NO_REPORT},
         '{bmc_pkg::REQ_END,  8'h00,                    1'b0, NO_REPORT},  // three opens left
         '{bmc_pkg::REQ_CHAR, bmc_pkg::CH_CLOSE_SQUARE, 1'b1,
           close_rep(8'd1, bmc_pkg::CH_CLOSE_SQUARE, 8'd0)},
         '{bmc_pkg::REQ_CHAR, bmc_pkg::CH_CLOSE_CURLY,  1'b1,
           close_rep(8'd2, bmc_pkg::CH_CLOSE_CURLY, 8'd1)},
         '{bmc_pkg::REQ_END,  8'h00,                    1'b1, summary_rep(1'b0, 8'd2)},
         '{bmc_pkg::REQ_END,  8'hFF,                    1'b1, summary_rep(1'b1, 8'd0)}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer(directed_rows[i].is_end, directed_rows[i].ch, directed_rows[i].typed,
               directed_rows[i].rep);
      wait_drained();

      repeat (6) send_expression($urandom_range(0, 14), $urandom_range(99) < 80);
      wait_drained();

      // fill the stack past its depth; the long output stall starts at the brim
      opens = 0;
      held = 1'b0;
      target = bmc_pkg::STACK_DEPTH + $urandom_range(1, 4);
      while (opens < target) begin
         if (opens == bmc_pkg::STACK_DEPTH && !held) begin
            hold_requests <= hold_requests + 1;
            held = 1'b1;
         end
         if ($urandom_range(9) == 0)
            offer(bmc_pkg::REQ_CHAR, 8'h30 + 8'($urandom_range(9)), 1'b0, NO_REPORT);
         else begin
            offer(bmc_pkg::REQ_CHAR, open_char_for(2'($urandom_range(2))), 1'b0, NO_REPORT);
            opens++;
         end
      end
      offer(bmc_pkg::REQ_END, 8'($urandom_range(255)), 1'b0, NO_REPORT);
      send_expression(6, 1'b0);
      wait_drained();

      // stray closes at full rate: position and error count both saturate
      steady_mode <= 1'b1;
      for (int i = 0; i < 262; i++)
         offer(bmc_pkg::REQ_CHAR, close_char_for(2'($urandom_range(2))), 1'b0, NO_REPORT);
      offer(bmc_pkg::REQ_END, 8'($urandom_range(255)), 1'b0, NO_REPORT);
      wait_drained();
      steady_mode <= 1'b0;

      repeat (4) send_expression($urandom_range(0, 14), $urandom_range(99) < 80);
      wait_drained();
      repeat (16) @(posedge clock);

      if (awaited_reports.size() != 0) begin
         $display("%0d expected reports never arrived", awaited_reports.size());
         fail_count += awaited_reports.size();
      end
      $display("%0d transactions in, %0d reports checked, %0d failures",
               items_in, reports_checked, fail_count);
      $display("reports by kind: close %0d, pair %0d, open %0d, overflow %0d, summary %0d",
               kinds_seen[bmc_pkg::KIND_UNMATCHED_CLOSE], kinds_seen[bmc_pkg::KIND_MISMATCH],
               kinds_seen[bmc_pkg::KIND_UNMATCHED_OPEN], kinds_seen[bmc_pkg::KIND_OVERFLOW],
               kinds_seen[bmc_pkg::KIND_SUMMARY]);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/bmc_pkg.sv
src/bmc_cell.sv
src/bmc_stack.sv
src/bracket_match_checker.sv
test/bracket_match_checker_tb.sv
